// ----- hw/rtl/bzr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzr_pkg: shared types and constants for the cubic Bezier evaluator
// Coordinate, parameter and datapath widths, reset control points,
// configuration register indexes and derivative saturation limits.
// ----------------------------------------------------------------------------
package bzr_pkg;

  // Field widths
  localparam int COORD_W   = 24;                // signed Q15.8 coordinate
  localparam int T_FRAC    = 16;                // fraction bits of t
  localparam int T_W       = T_FRAC + 1;        // t covers 0 .. 1.0 inclusive
  localparam int SLOPE_W   = COORD_W + 3;       // signed Q18.8 derivative
  localparam int CFG_IDX_W = 3;

  // Cell datapath widths: operands carry 3*(b-a), mix is a*2^F + t*(b-a)
  localparam int OP_W   = COORD_W + 3;
  localparam int MIX_W  = OP_W + T_FRAC;
  localparam int PROD_W = OP_W + T_W + 1;

  localparam logic [T_W-1:0] ONE_T = T_W'(1 << T_FRAC);

  localparam logic signed [OP_W:0] SLOPE_MAX = (OP_W+1)'((1 <<< (SLOPE_W-1)) - 1);
  localparam logic signed [OP_W:0] SLOPE_MIN = (OP_W+1)'(-(1 <<< (SLOPE_W-1)));

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OP_W-1:0]    opnd_t;
  typedef logic signed [MIX_W-1:0]   mix_t;
  typedef logic signed [SLOPE_W-1:0] slope_t;
  typedef logic        [T_W-1:0]     tval_t;

  // Four control points along one axis
  typedef struct packed {
    coord_t c0;
    coord_t c1;
    coord_t c2;
    coord_t c3;
  } curve_pts_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } cfg_reg_t;

  // Reset control points
  localparam curve_pts_t RESET_PTS_X = '{c0: 24'sd0, c1: 24'sd0, c2: 24'sd256, c3: 24'sd256};
  localparam curve_pts_t RESET_PTS_Y = '{c0: 24'sd0, c1: 24'sd256, c2: 24'sd256, c3: 24'sd0};

endpackage
`default_nettype wire

// ----- hw/rtl/cubic_bezier_point_and_tangent.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_point_and_tangent: 2D cubic Bezier point and derivative
// done and the result leave the three registered ranks of blend cells together.
// Throughput: one item per clock while busy is low, since every rank
// of blend cells is registered. Results cannot be stalled; each is shown for
// one cycle with done.
// Reset clears the item pipeline, loads the default control points and holds
// busy high for one cycle after reset.
// ----------------------------------------------------------------------------
module cubic_bezier_point_and_tangent
  import bzr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tval_t                param_t,
  output logic                 done,
  output coord_t               point_x,
  output coord_t               point_y,
  output slope_t               slope_x,
  output slope_t               slope_y,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  coord_t               cfg_data
);

  curve_pts_t pts_x, pts_y;
  tval_t      t_clamped;
  logic [2:0] vld;
  logic       accept;
  coord_t     x_lo, x_hi, y_lo, y_hi;

  // Control point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pts_x <= RESET_PTS_X;
      pts_y <= RESET_PTS_Y;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_P0_X: pts_x.c0 <= cfg_data;
        REG_P0_Y: pts_y.c0 <= cfg_data;
        REG_P1_X: pts_x.c1 <= cfg_data;
        REG_P1_Y: pts_y.c1 <= cfg_data;
        REG_P2_X: pts_x.c2 <= cfg_data;
        REG_P2_Y: pts_y.c2 <= cfg_data;
        REG_P3_X: pts_x.c3 <= cfg_data;
        REG_P3_Y: pts_y.c3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp t to 1.0
  assign t_clamped = (param_t > ONE_T) ? ONE_T : param_t;
  assign accept    = start && !busy;

  // Track items through the three ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      busy <= 1'b1;
    end else begin
      vld  <= {vld[1:0], accept};
      busy <= 1'b0;
    end
  end

  assign done = vld[2];

  bzr_lane u_lane_x (
    .clk  (clk),
    .pts  (pts_x),
    .t    (t_clamped),
    .point(point_x),
    .slope(slope_x)
  );

  bzr_lane u_lane_y (
    .clk  (clk),
    .pts  (pts_y),
    .t    (t_clamped),
    .point(point_y),
    .slope(slope_y)
  );

  // Bounding box of the control points, for checking
  always_comb begin
    x_lo = pts_x.c0;
    x_hi = pts_x.c0;
    y_lo = pts_y.c0;
    y_hi = pts_y.c0;
    if (pts_x.c1 < x_lo) x_lo = pts_x.c1;
    if (pts_x.c2 < x_lo) x_lo = pts_x.c2;
    if (pts_x.c3 < x_lo) x_lo = pts_x.c3;
    if (pts_x.c1 > x_hi) x_hi = pts_x.c1;
    if (pts_x.c2 > x_hi) x_hi = pts_x.c2;
    if (pts_x.c3 > x_hi) x_hi = pts_x.c3;
    if (pts_y.c1 < y_lo) y_lo = pts_y.c1;
    if (pts_y.c2 < y_lo) y_lo = pts_y.c2;
    if (pts_y.c3 < y_lo) y_lo = pts_y.c3;
    if (pts_y.c1 > y_hi) y_hi = pts_y.c1;
    if (pts_y.c2 > y_hi) y_hi = pts_y.c2;
    if (pts_y.c3 > y_hi) y_hi = pts_y.c3;
  end

  // done is raised only for an item that was accepted and has passed the three ranks
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("done without an item accepted three cycles earlier");

  // The point lies inside the control points' bounding box
  a_point_hull: assert property (@(posedge clk) disable iff (rst)
    done |-> (point_x >= $past(x_lo, 3) && point_x <= $past(x_hi, 3) &&
              point_y >= $past(y_lo, 3) && point_y <= $past(y_hi, 3)))
    else $error("point outside control point bounds");

  // t of zero returns the first control point
  a_point_start: assert property (@(posedge clk) disable iff (rst)
    (accept && param_t == '0) |-> ##3
      (done && point_x == $past(pts_x.c0, 3) && point_y == $past(pts_y.c0, 3)))
    else $error("t of zero does not give the first control point");

  // t of one or more returns the last control point
  a_point_end: assert property (@(posedge clk) disable iff (rst)
    (accept && param_t >= ONE_T) |-> ##3
      (done && point_x == $past(pts_x.c3, 3) && point_y == $past(pts_y.c3, 3)))
    else $error("t of one does not give the last control point");

endmodule
`default_nettype wire

// ----- hw/rtl/bzr_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzr_cell: one interpolation cell of the evaluation chain
// Registers the exact scaled blend a*2^F + t*(b-a) and hands t on to the
// next rank of cells.
// ----------------------------------------------------------------------------
module bzr_cell
  import bzr_pkg::*;
(
  input  logic  clk,
  input  opnd_t a,
  input  opnd_t b,
  input  tval_t t_in,
  output mix_t  mix,
  output tval_t t_out
);

  logic signed [OP_W:0]     diff;
  logic signed [T_W:0]      t_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] a_scaled;
  logic signed [PROD_W-1:0] sum;

  // Blend: one subtract, one multiply and one add
  assign diff     = {b[OP_W-1], b} - {a[OP_W-1], a};
  assign t_s      = {1'b0, t_in};
  assign prod     = diff * t_s;
  assign a_scaled = {{(PROD_W-OP_W){a[OP_W-1]}}, a} <<< T_FRAC;
  assign sum      = a_scaled + prod;

  // Hold the blend and pass t to the neighbor
  always_ff @(posedge clk) begin
    mix   <= sum[MIX_W-1:0];
    t_out <= t_in;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bzr_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzr_lane: point and derivative chain for one axis
// Three ranks of blend cells: de Casteljau levels for the point, and an
// exact two-level blend of the scaled differences for the derivative.
// ----------------------------------------------------------------------------
module bzr_lane
  import bzr_pkg::*;
(
  input  logic       clk,
  input  curve_pts_t pts,
  input  tval_t      t,
  output coord_t     point,
  output slope_t     slope
);

  opnd_t e0, e1, e2, e3;
  opnd_t d0, d1, d2;
  opnd_t q0, q1, q2;

  mix_t  ab_m, bc_m, cd_m, s_m, r_m;
  mix_t  abc_m, bcd_m, hi_m, lo_m;
  mix_t  pt_m;
  tval_t t_a, t_b;

  opnd_t ab_f, bc_f, cd_f, sh, rh, sl, rl;
  opnd_t abc_f, bcd_f;

  logic signed [MIX_W:0] fin_sum;
  logic signed [OP_W:0]  fin_v;
  logic signed [OP_W:0]  fin_sat;

  // Widen control points and form 3*(next - this)
  assign e0 = {{(OP_W-COORD_W){pts.c0[COORD_W-1]}}, pts.c0};
  assign e1 = {{(OP_W-COORD_W){pts.c1[COORD_W-1]}}, pts.c1};
  assign e2 = {{(OP_W-COORD_W){pts.c2[COORD_W-1]}}, pts.c2};
  assign e3 = {{(OP_W-COORD_W){pts.c3[COORD_W-1]}}, pts.c3};
  assign d0 = e1 - e0;
  assign d1 = e2 - e1;
  assign d2 = e3 - e2;
  assign q0 = (d0 <<< 1) + d0;
  assign q1 = (d1 <<< 1) + d1;
  assign q2 = (d2 <<< 1) + d2;

  // First rank
  bzr_cell u_ab (.clk(clk), .a(e0), .b(e1), .t_in(t), .mix(ab_m), .t_out(t_a));
  bzr_cell u_bc (.clk(clk), .a(e1), .b(e2), .t_in(t), .mix(bc_m), .t_out());
  bzr_cell u_cd (.clk(clk), .a(e2), .b(e3), .t_in(t), .mix(cd_m), .t_out());
  bzr_cell u_s  (.clk(clk), .a(q0), .b(q1), .t_in(t), .mix(s_m),  .t_out());
  bzr_cell u_r  (.clk(clk), .a(q1), .b(q2), .t_in(t), .mix(r_m),  .t_out());

  // Floor the point blends; split the derivative blends into high and low parts
  assign ab_f = ab_m[MIX_W-1:T_FRAC];
  assign bc_f = bc_m[MIX_W-1:T_FRAC];
  assign cd_f = cd_m[MIX_W-1:T_FRAC];
  assign sh   = s_m[MIX_W-1:T_FRAC];
  assign rh   = r_m[MIX_W-1:T_FRAC];
  assign sl   = {{(OP_W-T_FRAC){1'b0}}, s_m[T_FRAC-1:0]};
  assign rl   = {{(OP_W-T_FRAC){1'b0}}, r_m[T_FRAC-1:0]};

  // Second rank
  bzr_cell u_abc (.clk(clk), .a(ab_f), .b(bc_f), .t_in(t_a), .mix(abc_m), .t_out(t_b));
  bzr_cell u_bcd (.clk(clk), .a(bc_f), .b(cd_f), .t_in(t_a), .mix(bcd_m), .t_out());
  bzr_cell u_hi  (.clk(clk), .a(sh),   .b(rh),   .t_in(t_a), .mix(hi_m),  .t_out());
  bzr_cell u_lo  (.clk(clk), .a(sl),   .b(rl),   .t_in(t_a), .mix(lo_m),  .t_out());

  assign abc_f = abc_m[MIX_W-1:T_FRAC];
  assign bcd_f = bcd_m[MIX_W-1:T_FRAC];

  // Third rank: final point blend
  bzr_cell u_pt (.clk(clk), .a(abc_f), .b(bcd_f), .t_in(t_b), .mix(pt_m), .t_out());

  // Combine high and low derivative parts, floor once, then clamp
  assign fin_sum = {hi_m[MIX_W-1], hi_m}
                 + {{(T_FRAC+1){1'b0}}, lo_m[MIX_W-1:T_FRAC]};
  assign fin_v   = fin_sum[MIX_W:T_FRAC];

  always_comb begin
    if (fin_v > SLOPE_MAX) begin
      fin_sat = SLOPE_MAX;
    end else if (fin_v < SLOPE_MIN) begin
      fin_sat = SLOPE_MIN;
    end else begin
      fin_sat = fin_v;
    end
  end

  // Hold the derivative alongside the third rank
  always_ff @(posedge clk) begin
    slope <= fin_sat[SLOPE_W-1:0];
  end

  assign point = pt_m[T_FRAC +: COORD_W];

endmodule
`default_nettype wire
